>>> hw/rtl/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/pcmf_pkg.sv
package pcmf_pkg;
	typedef enum logic [2:0] {
		FMT_INT16   = 3'd0,
		FMT_INT24   = 3'd1,
		FMT_INT32   = 3'd2,
		FMT_FLOAT32 = 3'd3,
		FMT_FLOAT64 = 3'd4
	} sample_format_t;

	localparam logic [2:0] FORMAT_RESET = 3'd2;
	localparam logic [31:0] FLOAT_INF = 32'h7F80_0000;
	localparam logic [31:0] FLOAT_QNAN = 32'h7FC0_0000;
endpackage

>>> hw/rtl/pcmf_if.sv
interface pcmf_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] raw_sample;
	logic        end_of_block;
	modport source (output valid, raw_sample, end_of_block, input ready);
	modport sink (input valid, raw_sample, end_of_block, output ready);
endinterface

interface pcmf_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] float_bits;
	logic        end_of_block_out;
	modport source (output valid, float_bits, end_of_block_out, input ready);
	modport sink (input valid, float_bits, end_of_block_out, output ready);
endinterface

>>> hw/rtl/pcmf_convert.sv
module pcmf_convert
	import pcmf_pkg::*;
(
	input  logic [2:0]  fmt,
	input  logic [63:0] raw,
	output logic [31:0] result
);
	// Unified path: magnitude mant (up to 53 bits) times 2^ex, normalized, rounded.
	logic        sgn;
	logic [52:0] mant;
	logic signed [12:0] ex;
	logic        special;
	logic [31:0] special_val;
	logic [5:0]  top;
	logic signed [13:0] big_e;
	logic signed [13:0] shift;
	logic [52:0] shift_amt_mask;
	logic [53:0] r;
	logic [52:0] rem;
	logic [52:0] half;
	logic [31:0] mag;
	logic [31:0] v32;
	logic [10:0] bexp;
	logic [51:0] frac;

	always_comb begin
		sgn = 1'b0;
		mant = '0;
		ex = '0;
		special = 1'b0;
		special_val = '0;
		v32 = '0;
		bexp = raw[62:52];
		frac = raw[51:0];
		unique case (fmt)
			FMT_INT16, FMT_INT24, FMT_INT32: begin
				if (fmt == FMT_INT16) begin
					sgn = raw[15];
					v32 = {{16{raw[15]}}, raw[15:0]};
					ex = -13'sd15;
				end else if (fmt == FMT_INT24) begin
					sgn = raw[23];
					v32 = {{8{raw[23]}}, raw[23:0]};
					ex = -13'sd23;
				end else begin
					sgn = raw[31];
					v32 = raw[31:0];
					ex = -13'sd31;
				end
				mant = {21'd0, (sgn ? (32'd0 - v32) : v32)};
				if (v32 == 32'd0) begin
					special = 1'b1;
					special_val = '0;
				end
			end
			FMT_FLOAT32: begin
				special = 1'b1;
				special_val = raw[31:0];
			end
			FMT_FLOAT64: begin
				sgn = raw[63];
				if (bexp == 11'h7FF) begin
					special = 1'b1;
					special_val = (frac == '0) ? {1'b1, FLOAT_INF[30:0]} & {sgn, 31'h7FFF_FFFF}
						: {sgn, FLOAT_QNAN[30:0] | {9'd0, frac[50:29]}};
				end else if (bexp == '0) begin
					mant = {1'b0, frac};
					ex = -13'sd1074;
					if (frac == '0) begin
						special = 1'b1;
						special_val = {sgn, 31'd0};
					end
				end else begin
					mant = {1'b1, frac};
					ex = $signed({2'b00, bexp}) - 13'sd1075;
				end
			end
			default: begin
				special = 1'b1;
				special_val = '0;
			end
		endcase
	end

	// Leading-one detect
	always_comb begin
		top = '0;
		for (int i = 0; i < 53; i++) begin
			if (mant[i])
				top = 6'(i);
		end
	end

	always_comb begin
		logic [52:0] shifted;
		logic [5:0]  sa;
		logic [10:0] base;
		shifted = '0;
		sa = '0;
		big_e = 14'($signed({8'd0, top})) + 14'(ex);
		base = '0;
		if (big_e >= -14'sd126) begin
			shift = 14'($signed({8'd0, top})) - 14'sd23;
			base = 11'(big_e + 14'sd126);
		end else begin
			shift = -14'sd149 - 14'(ex);
		end
		rem = '0;
		half = '0;
		shift_amt_mask = '0;
		if (shift <= 0) begin
			sa = 6'(-shift);
			r = 54'({1'b0, mant} << sa);
		end else if (shift >= 14'sd54) begin
			r = '0;
		end else begin
			sa = 6'(shift);
			shift_amt_mask = (53'd1 << sa) - 53'd1;
			rem = mant & shift_amt_mask;
			half = 53'd1 << (sa - 6'd1);
			shifted = mant >> sa;
			r = {1'b0, shifted};
			if (rem > half || (rem == half && shifted[0]))
				r = r + 54'd1;
		end
		r = r + {20'd0, base, 23'd0};
		if (r >= 54'h7F80_0000)
			mag = FLOAT_INF;
		else
			mag = r[31:0];
		result = special ? special_val : {sgn, mag[30:0]};
	end
endmodule

>>> hw/rtl/pcm_sample_to_float_converter_core.sv
// Converts one raw PCM sample per cycle to an IEEE single-precision pattern.
// Each sample passes through an input register, then a result register; one sample is
// accepted every cycle while the output side keeps taking beats. The format
// register selects int16/int24/int32 (scaled to [-1,1)), float32 pass-through,
// float64 narrowing, or zero for unused codes.
`include "assert_macros.svh"
module pcm_sample_to_float_converter_core
	import pcmf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_wdata,
	pcmf_in_if.sink    in_ch,
	pcmf_out_if.source out_ch
);
	logic [2:0]  fmt_q;
	logic        vld_s1, vld_s2;
	logic [63:0] raw_s1;
	logic        eob_s1, eob_s2;
	logic [31:0] res_s2;
	logic [31:0] conv;
	logic        adv_s2, adv_s1;

	assign adv_s2 = !vld_s2 || out_ch.ready;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign in_ch.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FORMAT_RESET;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (cfg_we)
				fmt_q <= cfg_wdata;
			if (adv_s1)
				vld_s1 <= in_ch.valid;
			if (adv_s2)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			raw_s1 <= in_ch.raw_sample;
			eob_s1 <= in_ch.end_of_block;
		end
		if (adv_s2) begin
			res_s2 <= conv;
			eob_s2 <= eob_s1;
		end
	end

	pcmf_convert u_conv (
		.fmt(fmt_q),
		.raw(raw_s1),
		.result(conv)
	);

	assign out_ch.valid = vld_s2;
	assign out_ch.float_bits = res_s2;
	assign out_ch.end_of_block_out = eob_s2;

	// hold a stalled beat
	`ASSERT_NEXT(a_hold, clk, arst_n, vld_s2 && !out_ch.ready, vld_s2 && $stable(res_s2))
	// a full pipe must not accept
	`ASSERT_IMPL(a_full, clk, arst_n, !(vld_s1 && vld_s2 && !out_ch.ready && in_ch.ready))
	// stage one drains into stage two
	`ASSERT_NEXT(a_move, clk, arst_n, vld_s1 && adv_s2, vld_s2)
endmodule
